### design/sst_pkg.sv
// Package for the s-expression token scanner: token kinds, scan modes,
// character codes and the result word type. No dependencies.
package sst_pkg;

	localparam int QDEPTH = 4;
	localparam int QW     = $clog2(QDEPTH);
	localparam int CW     = $clog2(QDEPTH + 1);

	typedef enum logic [3:0] {
		K_LPAR   = 4'd0,
		K_RPAR   = 4'd1,
		K_DOT    = 4'd2,
		K_QUOTE  = 4'd3,
		K_TRUE   = 4'd4,
		K_FALSE  = 4'd5,
		K_STRING = 4'd6,
		K_NUMBER = 4'd7,
		K_SYMBOL = 4'd8,
		K_END    = 4'd9,
		K_ERROR  = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE   = 3'd0,
		M_HASH   = 3'd1,
		M_STRING = 3'd2,
		M_MINUS  = 3'd3,
		M_NUMBER = 3'd4,
		M_SYMBOL = 3'd5,
		M_SKIP   = 3'd6
	} mode_t;

	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_out;
		logic        token_first;
		logic        token_final;
		logic        run_last;
	} res_t;

	function automatic res_t mk(kind_t k, logic [7:0] c, logic f, logic l);
		res_t r;
		r.kind        = k;
		r.char_out    = c;
		r.token_first = f;
		r.token_final = l;
		r.run_last    = 1'b0;
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

### design/sst_if.sv
// Channel interfaces for the s-expression token scanner: text bytes in,
// tagged token words out. Valid/ready handshake; no dependencies.
interface sst_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface sst_token_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] char_out;
	logic       token_first;
	logic       token_final;
	logic       run_last;

	modport source (output valid, output token_kind, output char_out,
		output token_first, output token_final, output run_last, input ready);
	modport sink   (input valid, input token_kind, input char_out,
		input token_first, input token_final, input run_last, output ready);
endinterface

### design/sexpr_token_scanner.sv
// Top level of the s-expression token scanner.
// Depends on sst_pkg and the channel interfaces in sst_if.sv.
//
// One text byte is taken per cycle while the queue has room, and classified in
// a single pass against the scan mode and the held lookahead character; its
// zero, one or two token words go into a four-word output queue, from which one
// word leaves per cycle while the receiver is ready. A byte is taken whenever at
// least two queue places are free, so bursts of two-word bytes (#t, #f, a
// bracket, quote or zero byte closing a number or symbol, errors on a zero byte)
// are paced by the output at one word per cycle. Number and symbol characters
// come out one byte late, as the following byte decides whether they end a token.
module sexpr_token_scanner
	import sst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	sst_text_if.sink          text,
	sst_token_if.source       token
);

	mode_t       mode_q, mode_d;
	logic [7:0]  held_q, held_d;
	logic        hfirst_q, hfirst_d;

	res_t        q_q [QDEPTH];
	logic [QW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	res_t        r0, r1;
	logic [1:0]  n;
	logic        push, pop;

	// start-of-token decode
	res_t        ires;
	logic        ivalid, ihold;
	mode_t       imode;

	logic [7:0]  c;
	mode_t       m;
	logic        go;
	kind_t       rkind;

	assign c = text.char_in;

	always_comb begin
		ires   = mk(K_END, CH_NUL, 1'b1, 1'b1);
		ivalid = 1'b0;
		ihold  = 1'b0;
		imode  = M_IDLE;
		unique case (c)
			CH_LPAR: begin
				ires = mk(K_LPAR, c, 1'b1, 1'b1); ivalid = 1'b1;
			end
			CH_RPAR: begin
				ires = mk(K_RPAR, c, 1'b1, 1'b1); ivalid = 1'b1;
			end
			CH_DOT: begin
				ires = mk(K_DOT, c, 1'b1, 1'b1); ivalid = 1'b1;
			end
			CH_QUOTE: begin
				ires = mk(K_QUOTE, c, 1'b1, 1'b1); ivalid = 1'b1;
			end
			CH_SPACE, CH_NL: begin
			end
			CH_HASH: begin
				imode = M_HASH;
			end
			CH_DQUOT: begin
				ires = mk(K_STRING, c, 1'b1, 1'b0); ivalid = 1'b1;
				imode = M_STRING;
			end
			CH_NUL: begin
				ivalid = 1'b1;
			end
			CH_MINUS: begin
				ihold = 1'b1; imode = M_MINUS;
			end
			default: begin
				ihold = 1'b1;
				imode = is_digit(c) ? M_NUMBER : M_SYMBOL;
			end
		endcase
	end

	always_comb begin
		m        = mode_q;
		if (mode_q == M_MINUS) begin
			m = is_digit(c) ? M_NUMBER : M_SYMBOL;
		end
		mode_d   = m;
		held_d   = held_q;
		hfirst_d = hfirst_q;
		r0       = mk(K_END, CH_NUL, 1'b1, 1'b1);
		r1       = mk(K_END, CH_NUL, 1'b1, 1'b1);
		n        = 2'd0;
		go       = 1'b0;
		rkind    = K_NUMBER;
		unique case (m)
			M_HASH: begin
				if (c == CH_T || c == CH_F) begin
					rkind  = (c == CH_T) ? K_TRUE : K_FALSE;
					r0     = mk(rkind, CH_HASH, 1'b1, 1'b0);
					r1     = mk(rkind, c, 1'b0, 1'b1);
					n      = 2'd2;
					mode_d = M_IDLE;
				end else begin
					r0 = mk(K_ERROR, c, 1'b1, 1'b1);
					if (c == CH_NUL) begin
						n = 2'd2; mode_d = M_IDLE;
					end else begin
						n = 2'd1; mode_d = M_SKIP;
					end
				end
			end
			M_STRING: begin
				if (c == CH_DQUOT) begin
					r0 = mk(K_STRING, c, 1'b0, 1'b1); n = 2'd1; mode_d = M_IDLE;
				end else if (c == CH_NUL) begin
					r0 = mk(K_ERROR, c, 1'b1, 1'b1); n = 2'd2; mode_d = M_IDLE;
				end else begin
					r0 = mk(K_STRING, c, 1'b0, 1'b0); n = 2'd1;
				end
			end
			M_NUMBER, M_SYMBOL: begin
				if (m == M_NUMBER) begin
					rkind = K_NUMBER;
					go    = is_digit(c) || c == CH_DOT || c == CH_MINUS;
				end else begin
					rkind = K_SYMBOL;
					go    = c != CH_SPACE && c != CH_NL && c != CH_NUL &&
						c != CH_LPAR && c != CH_RPAR;
				end
				if (go) begin
					r0       = mk(rkind, held_q, hfirst_q, 1'b0);
					n        = 2'd1;
					held_d   = c;
					hfirst_d = 1'b0;
				end else begin
					r0     = mk(rkind, held_q, hfirst_q, 1'b1);
					r1     = ires;
					n      = ivalid ? 2'd2 : 2'd1;
					mode_d = imode;
					if (ihold) begin
						held_d = c; hfirst_d = 1'b1;
					end
				end
			end
			M_SKIP: begin
				if (c == CH_NUL) begin
					n = 2'd1; mode_d = M_IDLE;
				end
			end
			default: begin
				r0     = ires;
				n      = ivalid ? 2'd1 : 2'd0;
				mode_d = imode;
				if (ihold) begin
					held_d = c; hfirst_d = 1'b1;
				end
			end
		endcase
		if (n == 2'd1) begin
			r0.run_last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.run_last = 1'b1;
		end
	end

	assign text.ready = cnt_q <= CW'(QDEPTH - 2);
	assign push       = text.valid && text.ready;
	assign pop        = token.valid && token.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			held_q   <= CH_NUL;
			hfirst_q <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				mode_q   <= mode_d;
				held_q   <= held_d;
				hfirst_q <= hfirst_d;
				wr_ptr_q <= wr_ptr_q + QW'(n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			cnt_q <= cnt_q + (push ? CW'(n) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (push && n != 2'd0) begin
			q_q[wr_ptr_q] <= r0;
		end
		if (push && n == 2'd2) begin
			q_q[wr_ptr_q + QW'(1)] <= r1;
		end
	end

	assign token.valid       = cnt_q != '0;
	assign token.token_kind  = q_q[rd_ptr_q].kind;
	assign token.char_out    = q_q[rd_ptr_q].char_out;
	assign token.token_first = q_q[rd_ptr_q].token_first;
	assign token.token_final = q_q[rd_ptr_q].token_final;
	assign token.run_last    = q_q[rd_ptr_q].run_last;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QDEPTH))
		else $error("token queue overfilled");

	// a leading minus is the held character
	a_minus_held: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_MINUS |-> held_q == CH_MINUS)
		else $error("minus mode without held minus");

	// only number characters are held in number mode
	a_num_held: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_NUMBER |-> (is_digit(held_q) || held_q == CH_DOT ||
			held_q == CH_MINUS))
		else $error("non-number character held in number mode");

	// a word count is kept in step with the pointers
	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step");

endmodule
